// ===== sv/trap_pkg.sv =====
package trap_pkg;

  // default data and fraction widths
  localparam int unsigned DATA_WIDTH_DEF    = 16;
  localparam int unsigned FRACTION_BITS_DEF = 15;

  // configuration port
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 4;

  // register indexes
  typedef enum logic [1:0] {
    RegPointA = 2'd0,
    RegPointB = 2'd1,
    RegPointC = 2'd2,
    RegPointD = 2'd3
  } reg_idx_e;

  // region codes
  typedef enum logic [1:0] {
    RegionOut  = 2'd0,
    RegionRise = 2'd1,
    RegionFlat = 2'd2,
    RegionFall = 2'd3
  } region_e;

endpackage

// ===== sv/trapezoid_membership_eval_top.sv =====
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+--------------------------
// sample    | in        | valid_i / stall_o  | sample_i
// result    | out       | valid_o / stall_i  | grade_o, region_o
// config    | in        | apb psel / penable | paddr, pwdata -> prdata
//
// one sample enters per cycle unless stall_o is high; each result passes through
// one classify stage, then one restoring-divide stage per quotient bit.
// rst_ni clears the breakpoints and all stage valid bits.
// a stall on the output backs up only as far as the first empty stage, so
// bubbles inside the pipeline are filled while the output is held.
module trapezoid_membership_eval_top #(
  parameter int unsigned DATA_WIDTH    = trap_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = trap_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample channel
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [DATA_WIDTH-1:0]          sample_i,
  // result channel
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic [FRACTION_BITS:0]                grade_o,
  output logic [1:0]                            region_o,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [trap_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [trap_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [trap_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  localparam int unsigned NW   = DATA_WIDTH + 1;     // difference width
  localparam int unsigned QW   = FRACTION_BITS + 1;  // quotient width
  localparam int unsigned LAST = FRACTION_BITS + 1;  // index of output stage

  // breakpoint registers
  logic signed [DATA_WIDTH-1:0] pa_q, pb_q, pc_q, pd_q;
  logic                         wr_en;
  trap_pkg::reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = trap_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
      pd_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        trap_pkg::RegPointA: pa_q <= pwdata[DATA_WIDTH-1:0];
        trap_pkg::RegPointB: pb_q <= pwdata[DATA_WIDTH-1:0];
        trap_pkg::RegPointC: pc_q <= pwdata[DATA_WIDTH-1:0];
        trap_pkg::RegPointD: pd_q <= pwdata[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // register readback, sign extended
  always_comb begin
    unique case (reg_idx)
      trap_pkg::RegPointA: prdata = trap_pkg::APB_DATA_WIDTH'(pa_q);
      trap_pkg::RegPointB: prdata = trap_pkg::APB_DATA_WIDTH'(pb_q);
      trap_pkg::RegPointC: prdata = trap_pkg::APB_DATA_WIDTH'(pc_q);
      trap_pkg::RegPointD: prdata = trap_pkg::APB_DATA_WIDTH'(pd_q);
      default:             prdata = '0;
    endcase
  end

  // pipeline storage, one entry per stage
  logic               vld_q [0:LAST];
  logic               adv   [0:LAST];
  trap_pkg::region_e  reg_q [0:LAST];
  logic [NW-1:0]      rem_q [0:LAST];
  logic [NW-1:0]      den_q [0:LAST];
  logic [QW-1:0]      quo_q [0:LAST];

  // a stage loads when it is empty or its contents move on
  assign adv[LAST] = !vld_q[LAST] || !stall_i;
  for (genvar k = 0; k < LAST; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end
  assign stall_o = !adv[0];

  // classify: pick region, numerator and divisor
  logic in_rise, in_flat, in_fall;
  logic [NW-1:0]     rise_num, rise_den, fall_num, fall_den;
  trap_pkg::region_e cls_region_d;
  logic [NW-1:0]     cls_num_d, cls_den_d;

  assign in_rise  = (pa_q <= sample_i) && (sample_i < pb_q);
  assign in_flat  = (pb_q <= sample_i) && (sample_i < pc_q);
  assign in_fall  = (pc_q <= sample_i) && (sample_i < pd_q);
  assign rise_num = NW'($signed({sample_i[DATA_WIDTH-1], sample_i}) -
                        $signed({pa_q[DATA_WIDTH-1], pa_q}));
  assign rise_den = NW'($signed({pb_q[DATA_WIDTH-1], pb_q}) -
                        $signed({pa_q[DATA_WIDTH-1], pa_q}));
  assign fall_num = NW'($signed({pd_q[DATA_WIDTH-1], pd_q}) -
                        $signed({sample_i[DATA_WIDTH-1], sample_i}));
  assign fall_den = NW'($signed({pd_q[DATA_WIDTH-1], pd_q}) -
                        $signed({pc_q[DATA_WIDTH-1], pc_q}));

  // plateau divides 1 by 1 and outside divides 0 by 1, so the divider
  // produces the full and the zero grade with no extra select
  always_comb begin
    priority if (in_rise) begin
      cls_region_d = trap_pkg::RegionRise;
      cls_num_d    = rise_num;
      cls_den_d    = rise_den;
    end else if (in_flat) begin
      cls_region_d = trap_pkg::RegionFlat;
      cls_num_d    = NW'(1);
      cls_den_d    = NW'(1);
    end else if (in_fall) begin
      cls_region_d = trap_pkg::RegionFall;
      cls_num_d    = fall_num;
      cls_den_d    = fall_den;
    end else begin
      cls_region_d = trap_pkg::RegionOut;
      cls_num_d    = '0;
      cls_den_d    = NW'(1);
    end
  end

  // stage 0 valid and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv[0]) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && valid_i) begin
      reg_q[0] <= cls_region_d;
      rem_q[0] <= cls_num_d;
      den_q[0] <= cls_den_d;
      quo_q[0] <= '0;
    end
  end

  // restoring divide, one quotient bit per stage, msb first
  for (genvar k = 1; k <= LAST; k++) begin : g_div
    logic [NW:0]   trial;
    logic          q_bit;
    logic [NW:0]   diff;
    logic [NW-1:0] rem_d;

    // first step compares the numerator itself, later steps the doubled rest
    if (k == 1) begin : g_first
      assign trial = {1'b0, rem_q[k-1]};
    end else begin : g_next
      assign trial = {rem_q[k-1], 1'b0};
    end

    assign diff  = trial - {1'b0, den_q[k-1]};
    assign q_bit = (trial >= {1'b0, den_q[k-1]});
    assign rem_d = q_bit ? diff[NW-1:0] : trial[NW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && vld_q[k-1]) begin
        reg_q[k] <= reg_q[k-1];
        rem_q[k] <= rem_d;
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][QW-2:0], q_bit};
      end
    end
  end

  // last stage is the output register
  assign valid_o  = vld_q[LAST];
  assign grade_o  = quo_q[LAST];
  assign region_o = reg_q[LAST];

`ifndef SYNTH
  // plateau results carry the full grade
  a_flat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && region_o == trap_pkg::RegionFlat) |-> (grade_o == QW'(1) << FRACTION_BITS))
    else $error("plateau result without full grade");

  // outside results carry a zero grade
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && region_o == trap_pkg::RegionOut) |-> (grade_o == '0))
    else $error("outside result with nonzero grade");

  // grade never exceeds one
  a_grade_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (grade_o <= (QW'(1) << FRACTION_BITS)))
    else $error("grade above one");

  // an empty first stage never pushes back on the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> !stall_o)
    else $error("input stalled with empty first stage");
`endif

endmodule
